// ----- rtl/core/rmd_pkg.sv -----
`timescale 1ns / 1ps

package rmd_pkg;

	localparam int SIZE_LIMIT_CAP_DEF = 65536;
	localparam int MSG_W = 17;
	localparam int CNT_W = 18;
	localparam int IDX_W = 14;

	localparam logic [1:0] CFG_VER_A     = 2'd0;
	localparam logic [1:0] CFG_VER_B     = 2'd1;
	localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

	localparam logic [31:0]      VER_A_RST     = 32'd1;
	localparam logic [31:0]      VER_B_RST     = 32'd2;
	localparam logic [MSG_W-1:0] MAX_BYTES_RST = 17'd65536;

	localparam logic [2:0] PH_SIZE    = 3'd0;
	localparam logic [2:0] PH_VERSION = 3'd1;
	localparam logic [2:0] PH_CODE    = 3'd2;
	localparam logic [2:0] PH_ARGC    = 3'd3;
	localparam logic [2:0] PH_ARGLEN  = 3'd4;
	localparam logic [2:0] PH_ARGDATA = 3'd5;
	localparam logic [2:0] PH_TRAIL   = 3'd6;

	localparam logic [2:0] KIND_SIZE    = 3'd0;
	localparam logic [2:0] KIND_VERSION = 3'd1;
	localparam logic [2:0] KIND_CODE    = 3'd2;
	localparam logic [2:0] KIND_ARGC    = 3'd3;
	localparam logic [2:0] KIND_ARGLEN  = 3'd4;
	localparam logic [2:0] KIND_ARGDATA = 3'd5;
	localparam logic [2:0] KIND_IGNORED = 3'd6;

	localparam logic [2:0] ERR_OK          = 3'd0;
	localparam logic [2:0] ERR_VERSION     = 3'd1;
	localparam logic [2:0] ERR_OVERSIZE    = 3'd2;
	localparam logic [2:0] ERR_ARG_OVERRUN = 3'd3;
	localparam logic [2:0] ERR_SHORT_HDR   = 3'd4;

	localparam logic [31:0] MIN_HDR_BYTES = 32'd16;
	localparam logic [CNT_W-1:0] WORD_BYTES = 18'd4;

	typedef struct packed {
		logic [31:0]      ver_a;
		logic [31:0]      ver_b;
		logic [MSG_W-1:0] max_bytes;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       word_kind;
		logic [31:0]      field_value;
		logic [IDX_W-1:0] arg_index;
		logic [2:0]       valid_bytes;
		logic             arg_last;
		logic             msg_last;
		logic [2:0]       error_code;
	} result_t;

endpackage

// ----- rtl/core/rmd_cfg_regs.sv -----
`timescale 1ns / 1ps

module rmd_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	output rmd_pkg::cfg_t  cfg
);
	import rmd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg         = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ver_a     <= VER_A_RST;
			cfg_q.ver_b     <= VER_B_RST;
			cfg_q.max_bytes <= MAX_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VER_A:     cfg_q.ver_a     <= cfg_data;
				CFG_VER_B:     cfg_q.ver_b     <= cfg_data;
				CFG_MAX_BYTES: cfg_q.max_bytes <= cfg_data[MSG_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/rmd_parser.sv -----
`timescale 1ns / 1ps

module rmd_parser #(
	parameter int SIZE_LIMIT_CAP = rmd_pkg::SIZE_LIMIT_CAP_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [31:0]      word,
	input  rmd_pkg::cfg_t    cfg,
	output rmd_pkg::result_t res
);
	import rmd_pkg::*;

	logic [2:0]       phase_q,     phase_nxt;
	logic [MSG_W-1:0] msg_bytes_q, msg_bytes_nxt;
	logic [CNT_W-1:0] consumed_q,  consumed_nxt;
	logic [31:0]      args_q,      args_nxt;
	logic [IDX_W-1:0] arg_idx_q,   arg_idx_nxt;
	logic [15:0]      arg_bytes_q, arg_bytes_nxt;
	logic             ver_bad_q,   ver_bad_nxt;

	logic [MSG_W-1:0] lim;
	logic [CNT_W-1:0] cons_inc;
	logic [CNT_W-1:0] room;
	logic             ended;
	logic             to_size;
	logic             overrun;
	logic [15:0]      nlen;
	logic [2:0]       vb;
	logic [15:0]      bytes_after;

	always_comb begin
		if (int'(cfg.max_bytes) > SIZE_LIMIT_CAP) begin
			lim = MSG_W'(SIZE_LIMIT_CAP);
		end else begin
			lim = cfg.max_bytes;
		end
		cons_inc    = consumed_q + WORD_BYTES;
		ended       = cons_inc >= {1'b0, msg_bytes_q};
		room        = {1'b0, msg_bytes_q} - cons_inc;
		nlen        = word[15:0];
		vb          = (arg_bytes_q > 16'd4) ? 3'd4 : arg_bytes_q[2:0];
		bytes_after = arg_bytes_q - {13'd0, vb};

		phase_nxt     = phase_q;
		msg_bytes_nxt = msg_bytes_q;
		consumed_nxt  = consumed_q;
		args_nxt      = args_q;
		arg_idx_nxt   = arg_idx_q;
		arg_bytes_nxt = arg_bytes_q;
		ver_bad_nxt   = ver_bad_q;
		to_size       = 1'b0;
		overrun       = 1'b0;

		res.word_kind   = KIND_IGNORED;
		res.field_value = word;
		res.arg_index   = arg_idx_q;
		res.valid_bytes = 3'd0;
		res.arg_last    = 1'b0;
		res.msg_last    = 1'b0;
		res.error_code  = ERR_OK;

		if (phase_q == PH_SIZE) begin
			res.word_kind = KIND_SIZE;
			res.arg_index = '0;
			if (word > {15'd0, lim}) begin
				res.msg_last   = 1'b1;
				res.error_code = ERR_OVERSIZE;
				to_size        = 1'b1;
			end else if (word < MIN_HDR_BYTES) begin
				res.msg_last   = 1'b1;
				res.error_code = ERR_SHORT_HDR;
				to_size        = 1'b1;
			end else begin
				msg_bytes_nxt = word[MSG_W-1:0];
				consumed_nxt  = WORD_BYTES;
				ver_bad_nxt   = 1'b0;
				phase_nxt     = PH_VERSION;
			end
		end else begin
			consumed_nxt = cons_inc;
			case (phase_q)
				PH_VERSION: begin
					res.word_kind  = KIND_VERSION;
					res.arg_index  = '0;
					ver_bad_nxt    = (word != cfg.ver_a) && (word != cfg.ver_b);
					res.error_code = ver_bad_nxt ? ERR_VERSION : ERR_OK;
					phase_nxt      = PH_CODE;
				end
				PH_CODE: begin
					res.word_kind  = KIND_CODE;
					res.arg_index  = '0;
					res.error_code = ver_bad_q ? ERR_VERSION : ERR_OK;
					phase_nxt      = PH_ARGC;
				end
				PH_ARGC: begin
					res.word_kind = KIND_ARGC;
					res.arg_index = '0;
					args_nxt      = word;
					arg_idx_nxt   = '0;
					phase_nxt     = (word == 32'd0) ? PH_TRAIL : PH_ARGLEN;
				end
				PH_ARGLEN: begin
					res.word_kind   = KIND_ARGLEN;
					res.field_value = {16'd0, nlen};
					if (ended || ({2'd0, nlen} > room)) begin
						overrun = 1'b1;
					end else if (nlen == 16'd0) begin
						res.arg_last = 1'b1;
						args_nxt     = args_q - 32'd1;
						arg_idx_nxt  = arg_idx_q + 1'b1;
						phase_nxt    = (args_nxt == 32'd0) ? PH_TRAIL : PH_ARGLEN;
					end else begin
						arg_bytes_nxt = nlen;
						phase_nxt     = PH_ARGDATA;
					end
				end
				PH_ARGDATA: begin
					res.word_kind   = KIND_ARGDATA;
					res.valid_bytes = vb;
					arg_bytes_nxt   = bytes_after;
					if (bytes_after == 16'd0) begin
						res.arg_last = 1'b1;
						args_nxt     = args_q - 32'd1;
						arg_idx_nxt  = arg_idx_q + 1'b1;
						phase_nxt    = (args_nxt == 32'd0) ? PH_TRAIL : PH_ARGLEN;
					end
				end
				default: begin
					res.word_kind = KIND_IGNORED;
				end
			endcase

			if (overrun) begin
				res.msg_last   = 1'b1;
				res.error_code = ERR_ARG_OVERRUN;
				to_size        = 1'b1;
			end else if (ended) begin
				res.msg_last = 1'b1;
				if (args_nxt != 32'd0) begin
					res.error_code = ERR_ARG_OVERRUN;
				end else if (res.error_code == ERR_OK) begin
					res.error_code = ver_bad_nxt ? ERR_VERSION : ERR_OK;
				end
				to_size = 1'b1;
			end
		end

		if (to_size) begin
			phase_nxt     = PH_SIZE;
			consumed_nxt  = '0;
			args_nxt      = '0;
			arg_bytes_nxt = '0;
			ver_bad_nxt   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			msg_bytes_q <= '0;
			consumed_q  <= '0;
			args_q      <= '0;
			arg_idx_q   <= '0;
			arg_bytes_q <= '0;
			ver_bad_q   <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_nxt;
			msg_bytes_q <= msg_bytes_nxt;
			consumed_q  <= consumed_nxt;
			args_q      <= args_nxt;
			arg_idx_q   <= arg_idx_nxt;
			arg_bytes_q <= arg_bytes_nxt;
			ver_bad_q   <= ver_bad_nxt;
		end
	end

endmodule

// ----- rtl/core/rmd_out_stage.sv -----
`timescale 1ns / 1ps

module rmd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  rmd_pkg::result_t res,
	input  logic             out_stall,
	output logic             load_ok,
	output logic             out_valid,
	output rmd_pkg::result_t res_s2
);
	import rmd_pkg::*;

	logic valid_s2;

	assign load_ok   = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ok) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule

// ----- rtl/core/rpc_message_deframer.sv -----
`timescale 1ns / 1ps

// RPC message deframer: classifies a received message one 32-bit word per request.
// Input channel: in_valid / in_stall with rx_word, big-endian word already assembled.
// Output channel: out_valid / out_stall with word_kind, field_value, arg_index,
//   valid_bytes, arg_last, msg_last and error_code; exactly one result per word.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; write only while
//   idle. cfg_ready is always high. Index 0/1 accepted versions, 2 size limit.
// Pipeline: an accepted word is registered in the input stage, classified against
//   the parse state and registered in the output stage, where the receiver takes it.
// Throughput: one word per cycle while out_stall is low; the parse state is a set of
//   small counters that update in the same cycle the word moves into the output register.
// Stall: the output register holds its result while out_stall is high; the input
//   register then fills and in_stall rises, so at most two words are in flight.
// Reset: arst_n clears both stage valids, the parser returns to waiting for a size
//   word and the config registers take their defaults (versions 1 and 2, limit 65536).
module rpc_message_deframer #(
	parameter int SIZE_LIMIT_CAP = rmd_pkg::SIZE_LIMIT_CAP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] rx_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  word_kind,
	output logic [31:0] field_value,
	output logic [13:0] arg_index,
	output logic [2:0]  valid_bytes,
	output logic        arg_last,
	output logic        msg_last,
	output logic [2:0]  error_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rmd_pkg::*;

	cfg_t        cfg;
	result_t     res;
	result_t     res_s2;
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        load_ok;
	logic        adv;
	logic        accept;

	assign adv      = valid_s1 && load_ok;
	assign in_stall = valid_s1 && !load_ok;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= rx_word;
		end
	end

	rmd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rmd_parser #(
		.SIZE_LIMIT_CAP (SIZE_LIMIT_CAP)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.word   (word_s1),
		.cfg    (cfg),
		.res    (res)
	);

	rmd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_stall (out_stall),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign word_kind   = res_s2.word_kind;
	assign field_value = res_s2.field_value;
	assign arg_index   = res_s2.arg_index;
	assign valid_bytes = res_s2.valid_bytes;
	assign arg_last    = res_s2.arg_last;
	assign msg_last    = res_s2.msg_last;
	assign error_code  = res_s2.error_code;

endmodule

// ----- tb/rpc_message_deframer_tb.sv -----
`timescale 1ns / 1ps

module rpc_message_deframer_tb;
	import rmd_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [MSG_W-1:0] SIZE_CAP = SIZE_LIMIT_CAP_DEF;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [2:0]       phase;
		logic [MSG_W-1:0] msg_bytes;
		logic [CNT_W-1:0] consumed;
		logic [31:0]      args_left;
		logic [IDX_W-1:0] arg_idx;
		logic [15:0]      arg_bytes_left;
		logic             ver_bad;
	} parse_state_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] rx_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  word_kind;
	logic [31:0] field_value;
	logic [13:0] arg_index;
	logic [2:0]  valid_bytes;
	logic        arg_last;
	logic        msg_last;
	logic [2:0]  error_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	cfg_t         cfg_now = '{VER_A_RST, VER_B_RST, MAX_BYTES_RST};
	parse_state_t live_state;
	parse_state_t plan_state;
	result_t      predicted_words[$];
	logic [31:0]  rx_backlog[$];
	result_t      want_res, exp_res, got_res;

	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;
	logic msg_done;
	int   gap_left = 0;
	int   burst_left = 1;
	int   hold_req = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   mode_left = 0;
	int   stall_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;

	int fail_count = 0;
	int results_checked = 0;
	int words_queued = 0;
	int backpressure_cycles = 0;
	int regs_written = 0;
	int err_seen[5] = '{0, 0, 0, 0, 0};

	logic [31:0] directed_words[25] = '{
		32'd65537, 32'd0,
		32'd34, 32'd2, 32'd0, 32'd2, 32'hFFFF_0005, 32'hDEAD_BEEF, 32'h1234_5678,
		32'hA5A5_0000, 32'hFFFF_FFFF,
		32'd16, 32'hFFFF_FFFF, 32'd0, 32'd0,
		32'd24, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd100,
		32'd20, 32'd1, 32'd5, 32'd3, 32'd0
	};

	rpc_message_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_word(rx_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_kind(word_kind),
		.field_value(field_value),
		.arg_index(arg_index),
		.valid_bytes(valid_bytes),
		.arg_last(arg_last),
		.msg_last(msg_last),
		.error_code(error_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("** rpc_message_deframer: FAILED **");
		$finish;
	end

	function automatic logic [MSG_W-1:0] size_limit(input cfg_t c);
		return (c.max_bytes > SIZE_CAP) ? SIZE_CAP : c.max_bytes;
	endfunction

	task automatic classify_word(inout parse_state_t s, input cfg_t c, input logic [31:0] w,
			output result_t r);
		logic [MSG_W-1:0] lim;
		logic [15:0] nlen;
		logic ended;
		logic drop;
		r.word_kind = KIND_IGNORED;
		r.field_value = w;
		r.arg_index = s.arg_idx;
		r.valid_bytes = 3'd0;
		r.arg_last = 1'b0;
		r.msg_last = 1'b0;
		r.error_code = ERR_OK;
		drop = 1'b0;
		if (s.phase == PH_SIZE) begin
			lim = size_limit(c);
			r.word_kind = KIND_SIZE;
			r.arg_index = '0;
			if (w > {15'd0, lim}) begin
				r.msg_last = 1'b1;
				r.error_code = ERR_OVERSIZE;
				drop = 1'b1;
			end else if (w < MIN_HDR_BYTES) begin
				r.msg_last = 1'b1;
				r.error_code = ERR_SHORT_HDR;
				drop = 1'b1;
			end else begin
				s.msg_bytes = w[MSG_W-1:0];
				s.consumed = WORD_BYTES;
				s.ver_bad = 1'b0;
				s.phase = PH_VERSION;
			end
		end else begin
			s.consumed = s.consumed + WORD_BYTES;
			ended = s.consumed >= {1'b0, s.msg_bytes};
			case (s.phase)
				PH_VERSION: begin
					r.word_kind = KIND_VERSION;
					r.arg_index = '0;
					s.ver_bad = (w != c.ver_a) && (w != c.ver_b);
					r.error_code = s.ver_bad ? ERR_VERSION : ERR_OK;
					s.phase = PH_CODE;
				end
				PH_CODE: begin
					r.word_kind = KIND_CODE;
					r.arg_index = '0;
					r.error_code = s.ver_bad ? ERR_VERSION : ERR_OK;
					s.phase = PH_ARGC;
				end
				PH_ARGC: begin
					r.word_kind = KIND_ARGC;
					r.arg_index = '0;
					s.args_left = w;
					s.arg_idx = '0;
					s.phase = (w == 0) ? PH_TRAIL : PH_ARGLEN;
				end
				PH_ARGLEN: begin
					nlen = w[15:0];
					r.word_kind = KIND_ARGLEN;
					r.field_value = {16'd0, nlen};
					if (ended || int'(nlen) > int'(s.msg_bytes) - int'(s.consumed)) begin
						r.msg_last = 1'b1;
						r.error_code = ERR_ARG_OVERRUN;
						drop = 1'b1;
					end else if (nlen == 0) begin
						r.arg_last = 1'b1;
						s.args_left = s.args_left - 1;
						s.arg_idx = s.arg_idx + 1'b1;
						s.phase = (s.args_left == 0) ? PH_TRAIL : PH_ARGLEN;
					end else begin
						s.arg_bytes_left = nlen;
						s.phase = PH_ARGDATA;
					end
				end
				PH_ARGDATA: begin
					r.word_kind = KIND_ARGDATA;
					r.valid_bytes = (s.arg_bytes_left > 4) ? 3'd4 : s.arg_bytes_left[2:0];
					s.arg_bytes_left = s.arg_bytes_left - r.valid_bytes;
					if (s.arg_bytes_left == 0) begin
						r.arg_last = 1'b1;
						s.args_left = s.args_left - 1;
						s.arg_idx = s.arg_idx + 1'b1;
						s.phase = (s.args_left == 0) ? PH_TRAIL : PH_ARGLEN;
					end
				end
				default: r.word_kind = KIND_IGNORED;
			endcase
			if (ended && !drop) begin
				r.msg_last = 1'b1;
				if (s.args_left != 0)
					r.error_code = ERR_ARG_OVERRUN;
				else if (r.error_code == ERR_OK)
					r.error_code = s.ver_bad ? ERR_VERSION : ERR_OK;
				drop = 1'b1;
			end
		end
		if (drop) begin
			s.phase = PH_SIZE;
			s.consumed = '0;
			s.args_left = '0;
			s.arg_bytes_left = '0;
			s.ver_bad = 1'b0;
		end
	endtask

	// stimulus is trimmed at each predicted message end so sequences stay aligned
	task automatic queue_word(input logic [31:0] w, output logic ends);
		result_t r;
		rx_backlog.push_back(w);
		words_queued++;
		classify_word(plan_state, cfg_now, w, r);
		ends = r.msg_last;
	endtask

	task automatic gen_message();
		logic [31:0] words[$];
		logic [31:0] w;
		int nargs, len, pick, lim, size, j, k;
		logic done;
		lim = size_limit(cfg_now);
		nargs = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
		pick = $urandom_range(0, 9);
		words.push_back(32'd0);
		if (pick < 4)
			words.push_back(cfg_now.ver_a);
		else if (pick < 9)
			words.push_back(cfg_now.ver_b);
		else
			words.push_back($urandom);
		words.push_back($urandom);
		words.push_back(nargs);
		for (k = 0; k < nargs; k++) begin
			pick = $urandom_range(0, 99);
			w = $urandom;
			if (pick < 4) begin
				w[15:0] = 16'($urandom_range(41, 65535));
				words.push_back(w);
			end else begin
				len = (pick < 74) ? $urandom_range(0, 12) : $urandom_range(13, 40);
				w[15:0] = 16'(len);
				words.push_back(w);
				for (j = 0; j < (len + 3) / 4; j++)
					words.push_back($urandom);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			len = $urandom_range(1, 3);
			repeat (len) words.push_back($urandom);
		end
		size = words.size() * 4;
		if ($urandom_range(0, 3) == 0)
			size -= $urandom_range(1, 3);
		pick = $urandom_range(0, 99);
		if (pick < 8 && size > 16)
			size = $urandom_range(16, size);
		else if (pick < 13)
			words[3] = nargs + $urandom_range(1, 3);
		else if (pick < 15)
			words[3] = $urandom;
		else if (pick < 19 && nargs > 0)
			words[3] = nargs - 1;
		if (size > lim && $urandom_range(0, 1) == 0)
			size = lim;
		words[0] = size;
		done = 1'b0;
		for (j = 0; j < words.size() && !done; j++)
			queue_word(words[j], done);
	endtask

	task automatic gen_noise();
		int n, pick, lim;
		logic [31:0] w;
		logic done;
		lim = size_limit(cfg_now);
		n = $urandom_range(1, 3);
		repeat (n) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				w = $urandom;
				if (w <= 32'h1FFFF)
					w[31] = 1'b1;
			end else if (pick < 8) begin
				w = $urandom_range(0, 15);
			end else begin
				w = lim + 1;
			end
			queue_word(w, done);
		end
	endtask

	task automatic random_traffic(input int n);
		int stop_at;
		stop_at = words_queued + n;
		while (words_queued < stop_at) begin
			if ($urandom_range(0, 99) < 12)
				gen_noise();
			else
				gen_message();
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
		regs_written++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (rx_backlog.size() != 0 || in_valid || predicted_words.size() != 0);
		repeat (4) @(posedge clk);
		plan_state = live_state;
	endtask

	// sender: bursts of requests separated by random gaps
	always @(negedge clk) begin
		if (!(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (rx_backlog.size() != 0) begin
				rx_word <= rx_backlog.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: windows of different stall patterns, plus a long hold when requested
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			stall_tick++;
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (arst_n && in_valid && in_stall)
			backpressure_cycles++;
		if (in_taken) begin
			classify_word(live_state, cfg_now, rx_word, want_res);
			predicted_words.push_back(want_res);
		end
		if (cfg_taken) begin
			case (cfg_index)
				CFG_VER_A:     cfg_now.ver_a = cfg_data;
				CFG_VER_B:     cfg_now.ver_b = cfg_data;
				CFG_MAX_BYTES: cfg_now.max_bytes = cfg_data[MSG_W-1:0];
				default: ;
			endcase
		end
		if (arst_n && out_valid && !out_stall) begin
			got_res.word_kind = word_kind;
			got_res.field_value = field_value;
			got_res.arg_index = arg_index;
			got_res.valid_bytes = valid_bytes;
			got_res.arg_last = arg_last;
			got_res.msg_last = msg_last;
			got_res.error_code = error_code;
			if (error_code <= ERR_SHORT_HDR)
				err_seen[error_code]++;
			if (predicted_words.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result kind %0d value %h", $realtime,
						word_kind, field_value);
			end else begin
				exp_res = predicted_words.pop_front();
				results_checked++;
				if (got_res !== exp_res) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"%0t: mismatch exp/act kind %0d/%0d value %h/%h idx %0d/%0d",
							" bytes %0d/%0d alast %b/%b mlast %b/%b err %0d/%0d"}, $realtime,
							exp_res.word_kind, got_res.word_kind,
							exp_res.field_value, got_res.field_value,
							exp_res.arg_index, got_res.arg_index,
							exp_res.valid_bytes, got_res.valid_bytes,
							exp_res.arg_last, got_res.arg_last,
							exp_res.msg_last, got_res.msg_last,
							exp_res.error_code, got_res.error_code);
				end
			end
		end
	end

	initial begin
		logic [31:0] w;
		live_state = '0;
		live_state.phase = PH_SIZE;
		plan_state = live_state;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: framing errors, unaligned size, empty argument, bad version
		foreach (directed_words[i])
			queue_word(directed_words[i], msg_done);
		random_traffic(200);
		wait_idle();

		write_reg(CFG_VER_A, 32'd0);
		write_reg(CFG_VER_B, 32'hFFFF_FFFF);
		write_reg(CFG_MAX_BYTES, 32'd16);
		random_traffic(200);
		wait_idle();

		write_reg(CFG_UNUSED, $urandom);
		write_reg(CFG_MAX_BYTES, 32'hFFFF_FFFF);
		write_reg(CFG_VER_A, $urandom);
		write_reg(CFG_VER_B, $urandom);
		// one long message holding a single argument that fills it exactly
		queue_word(32'd512, msg_done);
		queue_word(cfg_now.ver_a, msg_done);
		queue_word($urandom, msg_done);
		queue_word(32'd1, msg_done);
		w = $urandom;
		w[15:0] = 16'd492;
		queue_word(w, msg_done);
		repeat (123) queue_word($urandom, msg_done);
		random_traffic(200);
		wait_idle();

		write_reg(CFG_MAX_BYTES, 32'hFFFE_0064);
		hold_req++;
		random_traffic(300);
		wait_idle();

		write_reg(CFG_VER_A, $urandom);
		write_reg(CFG_VER_B, cfg_now.ver_a);
		write_reg(CFG_MAX_BYTES, 32'd65536);
		random_traffic(300);
		wait_idle();

		write_reg(CFG_MAX_BYTES, $urandom_range(16, 2000));
		write_reg(CFG_VER_A, 32'd1);
		random_traffic(200);
		wait_idle();
		repeat (8) @(posedge clk);

		if (predicted_words.size() != 0) begin
			$display("%0d predicted results never came out", predicted_words.size());
			fail_count++;
		end
		$display("Checked %0d results from %0d words over %0d register writes.",
			results_checked, words_queued, regs_written);
		$display({"Error codes seen ok/ver/oversize/overrun/short %0d/%0d/%0d/%0d/%0d;",
			" input stalled %0d cycles."},
			err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4],
			backpressure_cycles);
		if (fail_count == 0)
			$display("** rpc_message_deframer: PASSED **");
		else
			$display("** rpc_message_deframer: FAILED **");
		$finish;
	end

endmodule
